// File: sv/drp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DNS response parser package
// Shared types and constants for the streaming DNS response parser.
// ----------------------------------------------------------------------------
package drp_pkg;

   localparam int unsigned HeaderBytes = 12;
   localparam int unsigned QfootBytes  = 4;
   localparam int unsigned FixedBytes  = 10;

   localparam logic [15:0] TYPE_A    = 16'd1;
   localparam logic [15:0] TYPE_AAAA = 16'd28;
   localparam logic [15:0] CLASS_IN  = 16'd1;
   localparam logic [15:0] LEN_A     = 16'd4;
   localparam logic [15:0] LEN_AAAA  = 16'd16;
   localparam logic [1:0]  PTR_TAG   = 2'b11;

   // Qualifier codes kept in the byte counter while in the record data.
   localparam logic [3:0] QUAL_NONE = 4'd0;
   localparam logic [3:0] QUAL_A    = 4'd1;
   localparam logic [3:0] QUAL_AAAA = 4'd2;
   // In a name, a counter value of one marks a pending pointer byte.
   localparam logic [3:0] PTR_PENDING = 4'd1;

   typedef enum logic [2:0] {
      SEC_HEADER = 3'd0,
      SEC_QNAME  = 3'd1,
      SEC_QFOOT  = 3'd2,
      SEC_ANAME  = 3'd3,
      SEC_AFIXED = 3'd4,
      SEC_RDATA  = 3'd5,
      SEC_DONE   = 3'd6
   } section_type;

   typedef enum logic [1:0] {
      KIND_IPV4    = 2'd0,
      KIND_IPV6    = 2'd1,
      KIND_SUMMARY = 2'd2
   } kind_type;

   typedef struct packed {
      section_type section;
      logic [3:0]  field_byte_count;
      logic [15:0] header_id;
      logic [15:0] questions_left;
      logic [15:0] answers_left;
      logic [7:0]  label_bytes_left;
      logic [15:0] record_type;
      logic [15:0] record_class;
      logic [31:0] record_ttl;
      logic [15:0] data_bytes_left;
      logic [31:0] address_shift;
      logic        valid_seen;
   } parse_state_type;

   localparam parse_state_type STATE_RESET = '{
      section:          SEC_HEADER,
      field_byte_count: '0,
      header_id:        '0,
      questions_left:   '0,
      answers_left:     '0,
      label_bytes_left: '0,
      record_type:      '0,
      record_class:     '0,
      record_ttl:       '0,
      data_bytes_left:  '0,
      address_shift:    '0,
      valid_seen:       1'b0
   };

   typedef struct packed {
      logic [7:0] byte_value;
      logic       end_of_packet;
   } in_item_type;

   typedef struct packed {
      logic        valid;
      kind_type    kind;
      logic [15:0] request_id;
      logic [31:0] ttl_seconds;
      logic [31:0] ipv4_address;
      logic        any_valid;
   } result_type;

endpackage

// File: sv/drp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DNS response parser channels
// Valid/ready channel interfaces for the message bytes and the results.
// ----------------------------------------------------------------------------
interface drp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] byte_value;
   logic       end_of_packet;

   modport source (output valid, output byte_value, output end_of_packet, input ready);
   modport sink   (input valid, input byte_value, input end_of_packet, output ready);
endinterface

interface drp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [15:0] request_id;
   logic [31:0] ttl_seconds;
   logic [31:0] ipv4_address;
   logic        any_valid;

   modport source (output valid, output kind, output request_id, output ttl_seconds,
                   output ipv4_address, output any_valid, input ready);
   modport sink   (input valid, input kind, input request_id, input ttl_seconds,
                   input ipv4_address, input any_valid, output ready);
endinterface

// File: sv/drp_in_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DNS response parser input register
// Holds one message byte until the parse stage takes it.
// ----------------------------------------------------------------------------
module drp_in_reg (
   input  logic               clock,
   input  logic               reset,
   drp_req_if.sink            req_if,
   input  logic               advance,
   output logic               item_valid,
   output drp_pkg::in_item_type item
);
   import drp_pkg::*;

   logic        valid_ff;
   logic        valid_in;
   in_item_type item_ff;
   logic        take;

   assign req_if.ready = !valid_ff || advance;
   assign take         = req_if.valid && req_if.ready;

   always_comb begin
      if (take) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= '{byte_value: req_if.byte_value, end_of_packet: req_if.end_of_packet};
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;
endmodule

// File: sv/drp_parse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DNS response parser state update
// Walks the header, questions and answers one byte at a time.
// ----------------------------------------------------------------------------
module drp_parse (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  drp_pkg::in_item_type item,
   output drp_pkg::result_type  result
);
   import drp_pkg::*;

   parse_state_type st_ff;
   parse_state_type st_in;
   parse_state_type upd;
   logic [7:0]      b;
   logic [3:0]      f;
   logic [3:0]      f_inc;
   logic            name_done;
   logic            rec_a;
   logic            rec_aaaa;
   logic [31:0]     rec_addr;

   assign b     = item.byte_value;
   assign f     = st_ff.field_byte_count;
   assign f_inc = f + 4'd1;

   always_comb begin
      upd       = st_ff;
      name_done = 1'b0;
      rec_a     = 1'b0;
      rec_aaaa  = 1'b0;
      rec_addr  = '0;

      case (st_ff.section)
         SEC_HEADER: begin
            if (f < 4'd2) begin
               upd.header_id = {st_ff.header_id[7:0], b};
            end else if (f == 4'd4 || f == 4'd5) begin
               upd.questions_left = {st_ff.questions_left[7:0], b};
            end else if (f == 4'd6 || f == 4'd7) begin
               upd.answers_left = {st_ff.answers_left[7:0], b};
            end
            if (f_inc >= 4'(HeaderBytes)) begin
               upd.field_byte_count = '0;
               upd.section = (upd.questions_left != '0) ? SEC_QNAME :
                             (upd.answers_left != '0) ? SEC_ANAME : SEC_DONE;
            end else begin
               upd.field_byte_count = f_inc;
            end
         end
         SEC_QNAME, SEC_ANAME: begin
            if (f == PTR_PENDING) begin
               upd.field_byte_count = '0;
               name_done = 1'b1;
            end else if (st_ff.label_bytes_left != '0) begin
               upd.label_bytes_left = st_ff.label_bytes_left - 8'd1;
            end else if (b[7:6] == PTR_TAG) begin
               upd.field_byte_count = PTR_PENDING;
            end else if (b == 8'd0) begin
               name_done = 1'b1;
            end else begin
               upd.label_bytes_left = b;
            end
            if (name_done) begin
               upd.section = (st_ff.section == SEC_QNAME) ? SEC_QFOOT : SEC_AFIXED;
            end
         end
         SEC_QFOOT: begin
            if (f_inc >= 4'(QfootBytes)) begin
               upd.field_byte_count = '0;
               upd.questions_left = st_ff.questions_left - 16'd1;
               upd.section = (upd.questions_left != '0) ? SEC_QNAME :
                             (st_ff.answers_left != '0) ? SEC_ANAME : SEC_DONE;
            end else begin
               upd.field_byte_count = f_inc;
            end
         end
         SEC_AFIXED: begin
            if (f < 4'd2) begin
               upd.record_type = {st_ff.record_type[7:0], b};
            end else if (f < 4'd4) begin
               upd.record_class = {st_ff.record_class[7:0], b};
            end else if (f < 4'd8) begin
               upd.address_shift = {st_ff.address_shift[23:0], b};
               if (f == 4'd7) begin
                  upd.record_ttl = upd.address_shift;
               end
            end else begin
               upd.data_bytes_left = {st_ff.data_bytes_left[7:0], b};
            end
            if (f_inc >= 4'(FixedBytes)) begin
               upd.address_shift = '0;
               if (upd.data_bytes_left == '0) begin
                  upd.answers_left     = st_ff.answers_left - 16'd1;
                  upd.field_byte_count = '0;
                  upd.label_bytes_left = '0;
                  upd.section = (upd.answers_left != '0) ? SEC_ANAME : SEC_DONE;
               end else begin
                  upd.field_byte_count = QUAL_NONE;
                  if (upd.record_class == CLASS_IN) begin
                     if (upd.record_type == TYPE_A && upd.data_bytes_left == LEN_A) begin
                        upd.field_byte_count = QUAL_A;
                     end else if (upd.record_type == TYPE_AAAA &&
                                  upd.data_bytes_left == LEN_AAAA) begin
                        upd.field_byte_count = QUAL_AAAA;
                     end
                  end
                  upd.section = SEC_RDATA;
               end
            end else begin
               upd.field_byte_count = f_inc;
            end
         end
         SEC_RDATA: begin
            upd.address_shift   = {st_ff.address_shift[23:0], b};
            upd.data_bytes_left = st_ff.data_bytes_left - 16'd1;
            if (upd.data_bytes_left == '0) begin
               if (f == QUAL_A) begin
                  rec_a          = 1'b1;
                  rec_addr       = upd.address_shift;
                  upd.valid_seen = 1'b1;
               end else if (f == QUAL_AAAA) begin
                  rec_aaaa       = 1'b1;
                  upd.valid_seen = 1'b1;
               end
               upd.answers_left     = st_ff.answers_left - 16'd1;
               upd.field_byte_count = '0;
               upd.label_bytes_left = '0;
               upd.address_shift    = '0;
               upd.section = (upd.answers_left != '0) ? SEC_ANAME : SEC_DONE;
            end
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      result.valid        = item.end_of_packet || rec_a || rec_aaaa;
      result.ttl_seconds  = upd.record_ttl;
      result.ipv4_address = rec_a ? rec_addr : '0;
      result.any_valid    = upd.valid_seen;
      if (item.end_of_packet) begin
         result.kind       = KIND_SUMMARY;
         result.request_id = (upd.section != SEC_HEADER) ? upd.header_id : '0;
      end else begin
         result.kind       = rec_a ? KIND_IPV4 : KIND_IPV6;
         result.request_id = upd.header_id;
      end
   end

   assign st_in = item.end_of_packet ? STATE_RESET : upd;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= STATE_RESET;
      end else if (advance) begin
         st_ff <= st_in;
      end
   end
endmodule

// File: sv/drp_out_reg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DNS response parser result register
// Holds one result until the downstream side takes it.
// ----------------------------------------------------------------------------
module drp_out_reg (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  drp_pkg::result_type result,
   output logic                can_load,
   drp_rsp_if.source           rsp_if
);
   import drp_pkg::*;

   logic       valid_ff;
   logic       valid_in;
   result_type data_ff;

   assign can_load = !valid_ff || rsp_if.ready;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_if.valid        = valid_ff;
   assign rsp_if.kind         = data_ff.kind;
   assign rsp_if.request_id   = data_ff.request_id;
   assign rsp_if.ttl_seconds  = data_ff.ttl_seconds;
   assign rsp_if.ipv4_address = data_ff.ipv4_address;
   assign rsp_if.any_valid    = data_ff.any_valid;
endmodule

// File: sv/dns_response_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DNS response parser
// Streams a DNS response one byte per request and reports A/AAAA answers.
// ----------------------------------------------------------------------------
// The parser takes one message byte per request, the last byte flagged by
// end_of_packet, and can accept a new byte in every clock cycle while no
// result is held up. A byte sits in the input register while the state
// update works on it, and any result it gives is loaded into the result
// register once that register can take it. Bytes that give no result keep
// flowing while a result waits for the downstream side; only a byte that
// gives a result has to wait for the result register to free up, and the
// input side stalls behind it for as long as that takes. An Internet-class A
// answer with four data bytes gives a kind 0 result with id, TTL and address;
// an Internet-class AAAA answer with sixteen data bytes gives a kind 1 result.
// The last byte of a message always gives a kind 2 summary, and the parser
// then starts afresh for the next message. Records cut short by the end of
// the message give nothing.
// ----------------------------------------------------------------------------
module dns_response_parser (
   input  logic      clock,
   input  logic      reset,
   drp_req_if.sink   req_if,
   drp_rsp_if.source rsp_if
);
   import drp_pkg::*;

   logic        item_valid;
   in_item_type item;
   result_type  result;
   logic        can_load;
   logic        advance;

   // A byte leaves the input register whenever the result register could
   // take whatever it produces; bytes that produce nothing move on too.
   assign advance = item_valid && (can_load || !result.valid);

   drp_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_if     (req_if),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   drp_parse u_parse (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item),
      .result  (result)
   );

   drp_out_reg u_out_reg (
      .clock    (clock),
      .reset    (reset),
      .load     (advance && result.valid),
      .result   (result),
      .can_load (can_load),
      .rsp_if   (rsp_if)
   );
endmodule

// File: verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// DNS response parser testbench
// Streams DNS responses through the parser byte by byte. A predictor in the
// bench follows the same header, question and answer walk and works out the
// expected IPv4, IPv6 and summary results. Every result is checked field by
// field, in order, while both sides idle and stall at random, then run flat out.
// ----------------------------------------------------------------------------
module tb;
   import drp_pkg::*;

   localparam int ClockPeriod = 4;
   localparam int ResetCycles = 12;
   localparam int DrainCycles = 20;
   localparam int CycleLimit  = 400000;

   typedef struct {
      kind_type    kind;
      logic [15:0] request_id;
      logic [31:0] ttl_seconds;
      logic [31:0] ipv4_address;
      logic        any_valid;
   } dns_answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   drp_req_if req_ch ();
   drp_rsp_if rsp_ch ();

   dns_response_parser u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   always #(ClockPeriod / 2) clock = ~clock;

   // Predicted parser state, updated once per accepted request.
   section_type sec;
   logic [3:0]  byte_idx;
   logic [15:0] msg_id;
   logic [15:0] q_left;
   logic [15:0] a_left;
   logic [7:0]  label_left;
   logic [15:0] rr_type;
   logic [15:0] rr_class;
   logic [31:0] rr_ttl;
   logic [15:0] rd_left;
   logic [31:0] shift_acc;
   logic        usable_seen;

   dns_answer_type expected_answers[$];
   logic [7:0]     msg_bytes[$];

   int errors        = 0;
   int bytes_sent    = 0;
   int messages_sent = 0;
   int seen_ipv4     = 0;
   int seen_ipv6     = 0;
   int seen_summary  = 0;
   int cycle_count   = 0;
   int send_idle_pct = 10;
   int stall_pct     = 10;
   int stall_left    = 0;
   bit calm          = 1'b0;

   function automatic void clear_parse_state();
      sec         = SEC_HEADER;
      byte_idx    = '0;
      msg_id      = '0;
      q_left      = '0;
      a_left      = '0;
      label_left  = '0;
      rr_type     = '0;
      rr_class    = '0;
      rr_ttl      = '0;
      rd_left     = '0;
      shift_acc   = '0;
      usable_seen = 1'b0;
   endfunction

   function automatic section_type section_after_questions();
      if (q_left != 0) return SEC_QNAME;
      return (a_left != 0) ? SEC_ANAME : SEC_DONE;
   endfunction

   function automatic void advance_answer();
      a_left     = a_left - 16'd1;
      byte_idx   = '0;
      label_left = '0;
      shift_acc  = '0;
      sec        = (a_left != 0) ? SEC_ANAME : SEC_DONE;
   endfunction

   // Walks one byte of a domain name; returns 1 when the name is complete.
   function automatic bit name_done(input logic [7:0] b);
      if (byte_idx == PTR_PENDING) begin
         byte_idx = '0;
         return 1'b1;
      end
      if (label_left != 0) begin
         label_left = label_left - 8'd1;
         return 1'b0;
      end
      if (b[7:6] == PTR_TAG) begin
         byte_idx = PTR_PENDING;
         return 1'b0;
      end
      if (b == 8'h00) return 1'b1;
      label_left = b;
      return 1'b0;
   endfunction

   // Advances the predicted state by one byte; returns 1 when a result is due.
   function automatic bit parse_byte(input logic [7:0] b, input logic eop,
                                     output dns_answer_type res);
      logic [3:0]  f;
      bit          got;
      kind_type    got_kind;
      logic [31:0] got_addr;
      f        = byte_idx;
      got      = 1'b0;
      got_kind = KIND_IPV4;
      got_addr = '0;
      res      = '{KIND_IPV4, '0, '0, '0, 1'b0};
      case (sec)
         SEC_HEADER: begin
            if (f < 2) msg_id = {msg_id[7:0], b};
            else if (f == 4 || f == 5) q_left = {q_left[7:0], b};
            else if (f == 6 || f == 7) a_left = {a_left[7:0], b};
            f = f + 4'd1;
            if (f >= HeaderBytes) begin
               f   = '0;
               sec = section_after_questions();
            end
            byte_idx = f;
         end
         SEC_QNAME: begin
            if (name_done(b)) sec = SEC_QFOOT;
         end
         SEC_QFOOT: begin
            f = f + 4'd1;
            if (f >= QfootBytes) begin
               f      = '0;
               q_left = q_left - 16'd1;
               sec    = section_after_questions();
            end
            byte_idx = f;
         end
         SEC_ANAME: begin
            if (name_done(b)) sec = SEC_AFIXED;
         end
         SEC_AFIXED: begin
            if (f < 2) rr_type = {rr_type[7:0], b};
            else if (f < 4) rr_class = {rr_class[7:0], b};
            else if (f < 8) begin
               shift_acc = {shift_acc[23:0], b};
               if (f == 7) rr_ttl = shift_acc;
            end else rd_left = {rd_left[7:0], b};
            f = f + 4'd1;
            if (f >= FixedBytes) begin
               shift_acc = '0;
               if (rd_left == 0) begin
                  advance_answer();
               end else begin
                  // The byte counter now records whether the data qualifies.
                  byte_idx = QUAL_NONE;
                  if (rr_class == CLASS_IN && rr_type == TYPE_A && rd_left == LEN_A)
                     byte_idx = QUAL_A;
                  else if (rr_class == CLASS_IN && rr_type == TYPE_AAAA
                           && rd_left == LEN_AAAA)
                     byte_idx = QUAL_AAAA;
                  sec = SEC_RDATA;
               end
            end else begin
               byte_idx = f;
            end
         end
         SEC_RDATA: begin
            shift_acc = {shift_acc[23:0], b};
            rd_left   = rd_left - 16'd1;
            if (rd_left == 0) begin
               if (f == QUAL_A) begin
                  got         = 1'b1;
                  got_kind    = KIND_IPV4;
                  got_addr    = shift_acc;
                  usable_seen = 1'b1;
               end else if (f == QUAL_AAAA) begin
                  got         = 1'b1;
                  got_kind    = KIND_IPV6;
                  usable_seen = 1'b1;
               end
               advance_answer();
            end
         end
         default: begin
         end
      endcase

      // The last byte always yields the summary, which absorbs any record
      // that completed on that same byte.
      if (eop) begin
         res.kind         = KIND_SUMMARY;
         res.request_id   = (sec != SEC_HEADER) ? msg_id : 16'd0;
         res.ttl_seconds  = rr_ttl;
         res.ipv4_address = got_addr;
         res.any_valid    = usable_seen;
         clear_parse_state();
         return 1'b1;
      end
      if (got) begin
         res.kind         = got_kind;
         res.request_id   = msg_id;
         res.ttl_seconds  = rr_ttl;
         res.ipv4_address = got_addr;
         res.any_valid    = usable_seen;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   // ---- Message building ----

   function automatic void put8(input logic [7:0] v);
      msg_bytes.insert(msg_bytes.size(), v);
   endfunction

   function automatic void put16(input logic [15:0] v);
      put8(v[15:8]);
      put8(v[7:0]);
   endfunction

   function automatic void put32(input logic [31:0] v);
      put16(v[31:16]);
      put16(v[15:0]);
   endfunction

   function automatic void put_label(input logic [7:0] len);
      put8(len);
      repeat (len) put8(8'($urandom));
   endfunction

   // Mostly short labels; now and then a length byte with one top bit set,
   // which the parser must treat as an ordinary length.
   function automatic logic [7:0] random_label_len();
      if ($urandom_range(0, 19) == 0) return 8'($urandom_range(64, 191));
      return 8'($urandom_range(1, 12));
   endfunction

   // Name forms: 0 root only, 1 labels, 2 pointer, 3 labels then pointer.
   function automatic void put_name(input int form);
      if (form == 1 || form == 3) begin
         repeat ($urandom_range(1, 3)) put_label(random_label_len());
      end
      if (form >= 2) begin
         put8({PTR_TAG, 6'($urandom)});
         put8(8'($urandom));
      end else begin
         put8(8'h00);
      end
   endfunction

   function automatic void put_header(input logic [15:0] id, input logic [15:0] qd,
                                      input logic [15:0] an);
      put16(id);
      put16(16'($urandom));
      put16(qd);
      put16(an);
      put32($urandom);
   endfunction

   // A negative form means the caller has already written the owner name;
   // a negative fill gives random data bytes.
   function automatic void put_answer(input int form, input logic [15:0] rtype,
                                      input logic [15:0] rclass, input logic [15:0] rdlen,
                                      input logic [31:0] ttl, input int fill);
      if (form >= 0) put_name(form);
      put16(rtype);
      put16(rclass);
      put32(ttl);
      put16(rdlen);
      repeat (rdlen) put8(fill < 0 ? 8'($urandom) : 8'(fill));
   endfunction

   // ---- Driving ----

   task automatic send_byte(input logic [7:0] b, input logic eop);
      dns_answer_type res;
      int             gap;
      gap = 0;
      if (!calm && $urandom_range(0, 99) < send_idle_pct) gap = $urandom_range(1, 13);
      @(negedge clock);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.byte_value    <= b;
      req_ch.end_of_packet <= eop;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      if (parse_byte(b, eop, res)) expected_answers.insert(expected_answers.size(), res);
      bytes_sent++;
   endtask

   task automatic send_message();
      foreach (msg_bytes[i]) send_byte(msg_bytes[i], i == msg_bytes.size() - 1);
      messages_sent++;
   endtask

   // The result side stalls in bursts of random length.
   always @(negedge clock) begin
      if (calm || reset) begin
         rsp_ch.ready <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left--;
      end else if ($urandom_range(0, 99) < stall_pct) begin
         rsp_ch.ready <= 1'b0;
         stall_left = $urandom_range(0, 12);
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // ---- Checking ----

   function automatic void check_field(input string name, input logic [31:0] want_v,
                                       input logic [31:0] got_v);
      if (got_v !== want_v) begin
         $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want_v, got_v);
         errors++;
      end
   endfunction

   always @(posedge clock) begin : answer_check
      dns_answer_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         if (expected_answers.size() == 0) begin
            $display("%0t ns: unexpected result, expected none, actual kind %0d id %h",
                     $time, rsp_ch.kind, rsp_ch.request_id);
            errors++;
         end else begin
            want = expected_answers.pop_front();
            check_field("kind", 32'(want.kind), 32'(rsp_ch.kind));
            check_field("request_id", 32'(want.request_id), 32'(rsp_ch.request_id));
            check_field("ttl_seconds", want.ttl_seconds, rsp_ch.ttl_seconds);
            check_field("ipv4_address", want.ipv4_address, rsp_ch.ipv4_address);
            check_field("any_valid", 32'(want.any_valid), 32'(rsp_ch.any_valid));
            case (want.kind)
               KIND_IPV4: seen_ipv4++;
               KIND_IPV6: seen_ipv6++;
               default:   seen_summary++;
            endcase
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("Timeout after %0d cycles with %0d results outstanding.",
                  cycle_count, expected_answers.size());
         $display("FAIL dns_response_parser");
         $finish;
      end
   end

   // ---- Tests ----

   // Messages that stop inside or right at the end of the header, and one with bytes after it.
   task automatic test_short_headers();
      msg_bytes.delete();
      put8(8'hFF);
      send_message();
      msg_bytes.delete();
      repeat (11) put8(8'hFF);
      send_message();
      msg_bytes.delete();
      put_header(16'hFFFF, 16'd0, 16'd0);
      send_message();
      // Zero counts: bytes after the header are ignored.
      msg_bytes.delete();
      put_header(16'h0000, 16'd0, 16'd0);
      put8(8'hA5);
      put8(8'h5A);
      send_message();
   endtask

   // Qualifying and non-qualifying record types, field extremes, empty data.
   task automatic test_answer_types();
      msg_bytes.delete();
      put_header(16'h1234, 16'd1, 16'd7);
      put_name(1);
      put32($urandom);
      put_answer(1, TYPE_A, CLASS_IN, LEN_A, 32'h0000_0000, 8'h00);
      put_answer(2, TYPE_A, CLASS_IN, LEN_A, 32'hFFFF_FFFF, 8'hFF);
      put_answer(3, TYPE_AAAA, CLASS_IN, LEN_AAAA, $urandom, -1);
      put_answer(0, TYPE_A, CLASS_IN, LEN_A + 16'd1, $urandom, -1);
      put_answer(1, TYPE_AAAA, 16'd3, LEN_AAAA, $urandom, -1);
      put_answer(2, TYPE_A, CLASS_IN, 16'd0, $urandom, -1);
      put_answer(0, 16'hFFFF, 16'hFFFF, 16'd2, $urandom, -1);
      put8(8'h00);
      send_message();
   endtask

   // Long labels whose length byte has one top bit set, and pointers.
   task automatic test_name_forms();
      msg_bytes.delete();
      put_header(16'hBEEF, 16'd2, 16'd2);
      put_label(8'h40);
      put8(8'h00);
      put32($urandom);
      put8({PTR_TAG, 6'h00});
      put8(8'h0C);
      put32($urandom);
      put_label(8'h80);
      put8({PTR_TAG, 6'h3F});
      put8(8'hFF);
      put_answer(-1, TYPE_A, CLASS_IN, LEN_A, $urandom, -1);
      put_answer(3, TYPE_A, CLASS_IN, LEN_A, $urandom, -1);
      send_message();
   endtask

   // Records that end on the last byte or are cut short by it.
   task automatic test_cut_short();
      msg_bytes.delete();
      put_header(16'h0A0A, 16'd0, 16'd2);
      put_answer(1, TYPE_A, CLASS_IN, LEN_A, $urandom, -1);
      put_answer(2, TYPE_A, CLASS_IN, LEN_A, $urandom, -1);
      send_message();
      msg_bytes.delete();
      put_header(16'h0B0B, 16'd0, 16'd1);
      put_answer(1, TYPE_A, CLASS_IN, LEN_A, $urandom, -1);
      repeat (2) void'(msg_bytes.pop_back());
      send_message();
      msg_bytes.delete();
      put_header(16'h0C0C, 16'd0, 16'd1);
      put_answer(0, TYPE_AAAA, CLASS_IN, LEN_AAAA, $urandom, -1);
      send_message();
      msg_bytes.delete();
      put_header(16'h0D0D, 16'd0, 16'd1);
      put_answer(2, TYPE_A, CLASS_IN, LEN_A, $urandom, -1);
      repeat (8) void'(msg_bytes.pop_back());
      send_message();
      // A huge data length that the message never reaches.
      msg_bytes.delete();
      put_header(16'h0E0E, 16'd0, 16'd1);
      put_name(0);
      put16(TYPE_A);
      put16(CLASS_IN);
      put32($urandom);
      put16(16'hFFFF);
      repeat (5) put8(8'($urandom));
      send_message();
   endtask

   // Counts of 0xFFFF keep the walk going until the end of the message.
   task automatic test_count_wrap();
      msg_bytes.delete();
      put_header(16'h5555, 16'hFFFF, 16'd0);
      repeat (3) begin
         put_name($urandom_range(0, 3));
         put32($urandom);
      end
      send_message();
      msg_bytes.delete();
      put_header(16'hAAAA, 16'd0, 16'hFFFF);
      repeat (3) put_answer($urandom_range(0, 3), TYPE_A, CLASS_IN, LEN_A, $urandom, -1);
      send_message();
   endtask

   // Mostly well-formed responses with random content, plus cut messages
   // and pure noise.
   task automatic test_random_traffic(input int byte_goal);
      int start, n_q, n_a, pick, cut, form;
      start = bytes_sent;
      while (bytes_sent - start < byte_goal) begin
         send_idle_pct = calm ? 0 : 8 * $urandom_range(0, 2);
         stall_pct     = 6 * $urandom_range(0, 3);
         msg_bytes.delete();
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            repeat ($urandom_range(1, 20)) put8(8'($urandom));
         end else begin
            n_q = $urandom_range(0, 2);
            n_a = $urandom_range(0, 4);
            put_header(16'($urandom), 16'(n_q), 16'(n_a));
            repeat (n_q) begin
               put_name($urandom_range(0, 3));
               put32($urandom);
            end
            repeat (n_a) begin
               form = $urandom_range(0, 3);
               case ($urandom_range(0, 9))
                  0, 1, 2, 3: put_answer(form, TYPE_A, CLASS_IN, LEN_A, $urandom, -1);
                  4, 5: put_answer(form, TYPE_AAAA, CLASS_IN, LEN_AAAA, $urandom, -1);
                  6: put_answer(form, TYPE_A, $urandom_range(0, 1) ? CLASS_IN : 16'($urandom),
                                16'($urandom_range(0, 6)), $urandom, -1);
                  7: put_answer(form, TYPE_AAAA,
                                $urandom_range(0, 1) ? CLASS_IN : 16'($urandom),
                                16'($urandom_range(15, 17)), $urandom, -1);
                  default: put_answer(form, 16'($urandom), 16'($urandom),
                                      16'($urandom_range(0, 6)), $urandom, -1);
               endcase
            end
            if ($urandom_range(0, 3) == 0)
               repeat ($urandom_range(1, 3)) put8(8'($urandom));
            if (pick >= 80) begin
               cut       = $urandom_range(1, msg_bytes.size());
               msg_bytes = msg_bytes[0:cut-1];
            end
         end
         send_message();
      end
   endtask

   initial begin
      req_ch.valid         = 1'b0;
      req_ch.byte_value    = '0;
      req_ch.end_of_packet = 1'b0;
      clear_parse_state();
      repeat (ResetCycles) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_short_headers();
      test_answer_types();
      test_name_forms();
      test_cut_short();
      test_count_wrap();
      test_random_traffic(150);
      // Closing stretch with both sides running flat out.
      calm = 1'b1;
      test_random_traffic(50);

      @(negedge clock);
      req_ch.valid <= 1'b0;
      while (expected_answers.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      $display("Sent %0d messages in %0d bytes: short headers, name forms, record types,",
               messages_sent, bytes_sent);
      $display("cut records, count wrap; checked %0d IPv4, %0d IPv6, %0d summaries.",
               seen_ipv4, seen_ipv6, seen_summary);
      if (errors == 0) begin
         $display("PASS dns_response_parser");
      end else begin
         $display("FAIL dns_response_parser");
      end
      $finish;
   end

endmodule
